### rtl/core/jgr_pkg.sv
// Shared types, codes and constants for the joystick gesture recorder.
`default_nettype none
package jgr_pkg;

  typedef enum logic [1:0] {
    OP_REPORT     = 2'd0,
    OP_CONNECT    = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_UNUSED     = 2'd3
  } jgr_op_e;

  typedef enum logic [2:0] {
    ACT_PROCESSED    = 3'd0,
    ACT_LAG_STOP     = 3'd1,
    ACT_DISCONNECT   = 3'd2,
    ACT_STARTED      = 3'd3,
    ACT_TIMEOUT      = 3'd4,
    ACT_DONE         = 3'd5,
    ACT_CONNECTED    = 3'd6,
    ACT_DISCONNECTED = 3'd7
  } jgr_action_e;

  typedef enum logic [2:0] {
    REG_STOP_LAG   = 3'd0,
    REG_DISC_LAG   = 3'd1,
    REG_TIMEOUT    = 3'd2,
    REG_DIAG_TH    = 3'd3,
    REG_AXIS_TH    = 3'd4,
    REG_CENTER_TH  = 3'd5,
    REG_NONE_6     = 3'd6,
    REG_NONE_7     = 3'd7
  } jgr_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAG,
    S_DECIDE,
    S_REC,
    S_DUMP_RD,
    S_DUMP_OUT
  } jgr_state_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SINGLE,
    KIND_DUMP,
    KIND_RECORD
  } jgr_kind_e;

  typedef enum logic [3:0] {
    BR_NONE,
    BR_CONNECT,
    BR_DISC_EVT,
    BR_LAG_DISC,
    BR_LAG_STOP,
    BR_START,
    BR_IDLE,
    BR_TIMEOUT,
    BR_FINISH,
    BR_FINISH_EMPTY,
    BR_RECORD
  } jgr_branch_e;

  localparam int unsigned APB_AW = 5;

  localparam logic [15:0] RST_STOP_LAG  = 16'd300;
  localparam logic [15:0] RST_DISC_LAG  = 16'd5000;
  localparam logic [15:0] RST_TIMEOUT   = 16'd2000;
  localparam logic [7:0]  RST_DIAG_TH   = 8'd50;
  localparam logic [7:0]  RST_AXIS_TH   = 8'd100;
  localparam logic [7:0]  RST_CENTER_TH = 8'd10;

  localparam logic [6:0] SYM_NONE = 7'h00;
  localparam logic [6:0] SYM_1    = 7'h31;
  localparam logic [6:0] SYM_2    = 7'h32;
  localparam logic [6:0] SYM_3    = 7'h33;
  localparam logic [6:0] SYM_4    = 7'h34;
  localparam logic [6:0] SYM_FIVE = 7'h35;
  localparam logic [6:0] SYM_6    = 7'h36;
  localparam logic [6:0] SYM_7    = 7'h37;
  localparam logic [6:0] SYM_8    = 7'h38;
  localparam logic [6:0] SYM_9    = 7'h39;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [31:0]       now_ms;
    logic [7:0]        released_buttons;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } jgr_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic       dome_enabled;
    logic       motor_stop;
    logic [6:0] gesture_symbol;
    logic       last;
  } jgr_out_t;

  typedef struct packed {
    logic [15:0] stop_lag_ms;
    logic [15:0] disconnect_lag_ms;
    logic [15:0] gesture_timeout_ms;
    logic [7:0]  diagonal_threshold;
    logic [7:0]  axis_threshold;
    logic [7:0]  center_threshold;
  } jgr_cfg_t;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic decide;
    logic rec_step;
    logic rec_emit;
    logic dump_rd;
    logic dump_emit;
  } jgr_cmd_t;

  typedef struct packed {
    jgr_kind_e kind;
    logic      out_free;
    logic      rec_empty;
    logic      dump_last;
  } jgr_sts_t;

  function automatic logic [6:0] button_letter(input logic [2:0] idx);
    logic [6:0] ch;
    case (idx)
      3'd0: ch = 7'h58;
      3'd1: ch = 7'h4F;
      3'd2: ch = 7'h55;
      3'd3: ch = 7'h52;
      3'd4: ch = 7'h44;
      3'd5: ch = 7'h4C;
      3'd6: ch = 7'h50;
      default: ch = 7'h58;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### rtl/core/jgr_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module jgr_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 15,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/jgr_regs.sv
// APB configuration register file for the gesture recorder.
`default_nettype none
module jgr_regs import jgr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output jgr_cfg_t               cfg_o
);

  jgr_cfg_t cfg_q, cfg_d;
  jgr_reg_e sel;

  assign sel    = jgr_reg_e'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      case (sel)
        REG_STOP_LAG:  cfg_d.stop_lag_ms        = pwdata[15:0];
        REG_DISC_LAG:  cfg_d.disconnect_lag_ms  = pwdata[15:0];
        REG_TIMEOUT:   cfg_d.gesture_timeout_ms = pwdata[15:0];
        REG_DIAG_TH:   cfg_d.diagonal_threshold = pwdata[7:0];
        REG_AXIS_TH:   cfg_d.axis_threshold     = pwdata[7:0];
        REG_CENTER_TH: cfg_d.center_threshold   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_STOP_LAG:  prdata = {16'd0, cfg_q.stop_lag_ms};
      REG_DISC_LAG:  prdata = {16'd0, cfg_q.disconnect_lag_ms};
      REG_TIMEOUT:   prdata = {16'd0, cfg_q.gesture_timeout_ms};
      REG_DIAG_TH:   prdata = {24'd0, cfg_q.diagonal_threshold};
      REG_AXIS_TH:   prdata = {24'd0, cfg_q.axis_threshold};
      REG_CENTER_TH: prdata = {24'd0, cfg_q.center_threshold};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_lag_ms        <= RST_STOP_LAG;
      cfg_q.disconnect_lag_ms  <= RST_DISC_LAG;
      cfg_q.gesture_timeout_ms <= RST_TIMEOUT;
      cfg_q.diagonal_threshold <= RST_DIAG_TH;
      cfg_q.axis_threshold     <= RST_AXIS_TH;
      cfg_q.center_threshold   <= RST_CENTER_TH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/jgr_ctrl.sv
// Sequencing state machine of the gesture recorder.
`default_nettype none
module jgr_ctrl import jgr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire jgr_sts_t sts_i,
  output jgr_cmd_t      cmd_o
);

  jgr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LAG;
        end
      end
      S_LAG: state_d = S_DECIDE;
      S_DECIDE: begin
        if (sts_i.out_free) begin
          case (sts_i.kind)
            KIND_DUMP:   state_d = S_DUMP_RD;
            KIND_RECORD: state_d = S_REC;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_REC: begin
        if (sts_i.rec_empty && sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: state_d = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_LAG:    cmd_o.calc   = 1'b1;
      S_DECIDE: cmd_o.decide = sts_i.out_free;
      S_REC: begin
        cmd_o.rec_step = !sts_i.rec_empty;
        cmd_o.rec_emit = sts_i.rec_empty && sts_i.out_free;
      end
      S_DUMP_RD:  cmd_o.dump_rd   = 1'b1;
      S_DUMP_OUT: cmd_o.dump_emit = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/jgr_dp.sv
// Datapath of the gesture recorder: watchdog, capture state, symbol store and output register.
`default_nettype none
module jgr_dp import jgr_pkg::*; #(
  parameter int unsigned GESTURE_CHARS = 15
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire jgr_in_t  in_data_i,
  input  wire jgr_cfg_t cfg_i,
  input  wire jgr_cmd_t cmd_i,
  output jgr_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output jgr_out_t      out_data_o
);

  localparam int unsigned CW = $clog2(GESTURE_CHARS + 1);
  localparam int unsigned AW = (GESTURE_CHARS > 1) ? $clog2(GESTURE_CHARS) : 1;
  localparam logic [CW-1:0] FULL = CW'(GESTURE_CHARS);

  jgr_in_t     in_q, in_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] lag_q, lag_d;
  logic [31:0] late_q, late_d;
  logic [31:0] deadline_q, deadline_d;
  logic        coll_q, coll_d;
  logic        dome_q, dome_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [6:0]  latch_q, latch_d;
  logic [6:0]  last_sym_q, last_sym_d;
  logic [6:0]  dir_sym_q, dir_sym_d;
  logic [8:0]  pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  jgr_out_t    out_q, out_d;

  jgr_op_e     op;
  jgr_branch_e br;
  logic [31:0] new_deadline;
  logic        lag_disc, lag_stop, is_late, l3;
  logic [7:0]  ax, ay;
  logic        diag, straight_x, straight_y, centred, dir_fire;
  logic [6:0]  dir_sym, latch_mid, latch_new;
  logic [CW-1:0] n_fin;
  logic        out_free, dump_last;
  logic [8:0]  pend_low;
  logic [6:0]  rec_sym;
  logic        ram_we;
  logic [6:0]  ram_rdata;

  assign op           = jgr_op_e'(in_q.opcode);
  assign new_deadline = in_q.now_ms + {16'd0, cfg_i.gesture_timeout_ms};
  assign lag_disc     = lag_q > {16'd0, cfg_i.disconnect_lag_ms};
  assign lag_stop     = lag_q > {16'd0, cfg_i.stop_lag_ms};
  assign is_late      = (late_q != 32'd0) && !late_q[31];
  assign l3           = in_q.released_buttons[0];
  assign ax           = in_q.stick_x[7] ? 8'(8'd0 - in_q.stick_x) : in_q.stick_x;
  assign ay           = in_q.stick_y[7] ? 8'(8'd0 - in_q.stick_y) : in_q.stick_y;
  assign out_free     = !out_valid_q || out_ready_i;
  assign dump_last    = CW'(idx_q + CW'(1)) == n_q;

  assign n_fin = ((count_q != '0) && (last_sym_q == SYM_FIVE)) ? CW'(count_q - CW'(1)) : count_q;

  always_comb begin
    diag       = (ax > cfg_i.diagonal_threshold) && (ay > cfg_i.diagonal_threshold);
    straight_x = ax > cfg_i.axis_threshold;
    straight_y = ay > cfg_i.axis_threshold;
    dir_fire   = 1'b0;
    dir_sym    = SYM_NONE;
    if (latch_q == SYM_NONE) begin
      if (diag) begin
        dir_fire = 1'b1;
        if (in_q.stick_x[7]) begin
          dir_sym = in_q.stick_y[7] ? SYM_1 : SYM_7;
        end else begin
          dir_sym = in_q.stick_y[7] ? SYM_3 : SYM_9;
        end
      end else if (straight_x) begin
        dir_fire = 1'b1;
        dir_sym  = in_q.stick_x[7] ? SYM_4 : SYM_6;
      end else if (straight_y) begin
        dir_fire = 1'b1;
        dir_sym  = in_q.stick_y[7] ? SYM_2 : SYM_8;
      end
    end
    latch_mid = dir_fire ? dir_sym : latch_q;
    centred   = (latch_mid != SYM_NONE) && (ax < cfg_i.center_threshold) &&
                (ay < cfg_i.center_threshold);
    latch_new = centred ? SYM_NONE : latch_mid;
  end

  always_comb begin
    br = BR_NONE;
    case (op)
      OP_CONNECT:    br = BR_CONNECT;
      OP_DISCONNECT: br = BR_DISC_EVT;
      OP_REPORT: begin
        if (lag_disc) begin
          br = BR_LAG_DISC;
        end else if (lag_stop) begin
          br = BR_LAG_STOP;
        end else if (!coll_q) begin
          br = l3 ? BR_START : BR_IDLE;
        end else if (is_late) begin
          br = BR_TIMEOUT;
        end else if (l3) begin
          br = (n_fin == '0) ? BR_FINISH_EMPTY : BR_FINISH;
        end else begin
          br = BR_RECORD;
        end
      end
      default: br = BR_NONE;
    endcase
  end

  always_comb begin
    case (br)
      BR_NONE:   sts_o.kind = KIND_NONE;
      BR_FINISH: sts_o.kind = KIND_DUMP;
      BR_RECORD: sts_o.kind = KIND_RECORD;
      default:   sts_o.kind = KIND_SINGLE;
    endcase
    sts_o.out_free  = out_free;
    sts_o.rec_empty = pend_q == 9'd0;
    sts_o.dump_last = dump_last;
  end

  always_comb begin
    pend_low = pend_q & 9'(~pend_q + 9'd1);
    rec_sym  = SYM_FIVE;
    for (int i = 0; i < 7; i++) begin
      if (pend_low[i]) begin
        rec_sym = button_letter(3'(i));
      end
    end
    if (pend_low[7]) begin
      rec_sym = dir_sym_q;
    end
  end

  always_comb begin
    in_d        = in_q;
    prev_d      = prev_q;
    lag_d       = lag_q;
    late_d      = late_q;
    deadline_d  = deadline_q;
    coll_d      = coll_q;
    dome_d      = dome_q;
    count_d     = count_q;
    n_d         = n_q;
    idx_d       = idx_q;
    latch_d     = latch_q;
    last_sym_d  = last_sym_q;
    dir_sym_d   = dir_sym_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;

    if (cmd_i.load_in) begin
      in_d = in_data_i;
    end

    if (cmd_i.calc) begin
      lag_d  = (in_q.now_ms > prev_q) ? (in_q.now_ms - prev_q) : 32'd0;
      late_d = in_q.now_ms - deadline_q;
      if (op == OP_REPORT || op == OP_CONNECT) begin
        prev_d = in_q.now_ms;
      end
    end

    if (cmd_i.decide) begin
      out_d.gesture_symbol = SYM_NONE;
      out_d.last           = 1'b1;
      out_d.motor_stop     = 1'b0;
      case (br)
        BR_CONNECT: begin
          dome_d       = 1'b1;
          out_d.action = ACT_CONNECTED;
        end
        BR_DISC_EVT: begin
          dome_d           = 1'b0;
          out_d.action     = ACT_DISCONNECTED;
          out_d.motor_stop = 1'b1;
        end
        BR_LAG_DISC: begin
          out_d.action     = ACT_DISCONNECT;
          out_d.motor_stop = 1'b1;
        end
        BR_LAG_STOP: begin
          out_d.action     = ACT_LAG_STOP;
          out_d.motor_stop = 1'b1;
        end
        BR_START: begin
          dome_d           = 1'b0;
          coll_d           = 1'b1;
          count_d          = '0;
          deadline_d       = new_deadline;
          out_d.action     = ACT_STARTED;
          out_d.motor_stop = 1'b1;
        end
        BR_TIMEOUT: begin
          dome_d       = 1'b1;
          coll_d       = 1'b0;
          count_d      = '0;
          out_d.action = ACT_TIMEOUT;
        end
        BR_FINISH, BR_FINISH_EMPTY: begin
          dome_d       = 1'b1;
          coll_d       = 1'b0;
          count_d      = '0;
          n_d          = n_fin;
          idx_d        = '0;
          out_d.action = ACT_DONE;
        end
        BR_RECORD: begin
          latch_d   = latch_new;
          dir_sym_d = dir_sym;
          pend_d    = {centred, dir_fire, in_q.released_buttons[7:1]};
        end
        default: out_d.action = ACT_PROCESSED;
      endcase
      out_d.dome_enabled = dome_d;
      if (br != BR_NONE && br != BR_RECORD && br != BR_FINISH) begin
        out_valid_d = 1'b1;
      end else begin
        out_d = out_q;
      end
    end

    if (cmd_i.rec_step) begin
      pend_d = pend_q & ~pend_low;
      if (count_q < FULL) begin
        ram_we     = 1'b1;
        count_d    = CW'(count_q + CW'(1));
        last_sym_d = rec_sym;
        deadline_d = new_deadline;
      end
    end

    if (cmd_i.rec_emit) begin
      out_valid_d          = 1'b1;
      out_d.action         = ACT_PROCESSED;
      out_d.dome_enabled   = dome_q;
      out_d.motor_stop     = 1'b0;
      out_d.gesture_symbol = SYM_NONE;
      out_d.last           = 1'b1;
    end

    if (cmd_i.dump_emit) begin
      out_valid_d          = 1'b1;
      out_d.action         = ACT_DONE;
      out_d.dome_enabled   = dome_q;
      out_d.motor_stop     = 1'b0;
      out_d.gesture_symbol = ram_rdata;
      out_d.last           = dump_last;
      idx_d                = CW'(idx_q + CW'(1));
    end
  end

  jgr_ram #(
    .WIDTH (7),
    .DEPTH (GESTURE_CHARS)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (rec_sym),
    .re_i    (cmd_i.dump_rd),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      deadline_q  <= '0;
      coll_q      <= 1'b0;
      dome_q      <= 1'b0;
      count_q     <= '0;
      latch_q     <= SYM_NONE;
      last_sym_q  <= SYM_NONE;
      pend_q      <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      deadline_q  <= deadline_d;
      coll_q      <= coll_d;
      dome_q      <= dome_d;
      count_q     <= count_d;
      latch_q     <= latch_d;
      last_sym_q  <= last_sym_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    lag_q     <= lag_d;
    late_q    <= late_d;
    dir_sym_q <= dir_sym_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### rtl/core/joystick_gesture_recorder.sv
// Top level of the joystick gesture recorder.
//
// Items arrive on the input channel (in_valid_i/in_ready_o, payload in_data_i) and
// results leave on the output channel (out_valid_o/out_ready_i, payload out_data_o);
// each channel moves one item per transaction. Thresholds and limits are written
// through the APB port; the user must write them only while the block is idle,
// which the block itself does not enforce. The block works on one item at a time:
// the accepted item is registered, the LAG state measures the report gap and the
// gesture lateness, and the DECIDE state, once the output register is free, picks
// the branch and loads a single result. A recording report then steps through its
// symbol candidates (up to nine) one at a time, since the symbol store has a single
// write port. A finished gesture reads its stored symbols back one at a time,
// a read state then an output state per symbol, waiting while the output is stalled.
// Reset clears the capture state, the dome enable and out_valid_o and loads the
// default thresholds; the symbol store needs no clearing. When the receiver
// stalls, the pending result holds in the output register and the sequencer waits.
`default_nettype none
module joystick_gesture_recorder import jgr_pkg::*; #(
  parameter int unsigned GESTURE_CHARS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire jgr_in_t           in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output jgr_out_t               out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  jgr_cfg_t cfg;
  jgr_cmd_t cmd;
  jgr_sts_t sts;

  jgr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jgr_dp #(
    .GESTURE_CHARS (GESTURE_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.calc, cmd.decide, cmd.rec_step, cmd.rec_emit,
              cmd.dump_rd, cmd.dump_emit}))
    else $error("More than one datapath command in a cycle.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input taken while an item is still in progress.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rec_emit || cmd.dump_emit || cmd.decide) |-> sts.out_free)
    else $error("Result loaded while the output register is still occupied.");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the joystick gesture recorder: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jgr_pkg::*;

  localparam int unsigned GESTURE_CHARS = 15;
  localparam int unsigned RANDOM_PER_PHASE = 50;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Button letters for bits 1..7, lowest first: X O U R D L P.
  localparam logic [48:0] KEY_LETTERS = {7'h50, 7'h4C, 7'h44, 7'h52, 7'h55, 7'h4F, 7'h58};

  typedef struct {
    jgr_in_t  item;
    bit       typed;
    jgr_out_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  jgr_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  jgr_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor copy of the configuration and state.
  jgr_cfg_t    cfg;
  logic [31:0] prev_ms;
  logic [31:0] deadline_ms;
  bit          capturing;
  bit          dome;
  logic [6:0]  stored [GESTURE_CHARS];
  int unsigned stored_n;
  logic [6:0]  held_dir;
  jgr_out_t    outcome[$];
  jgr_out_t    results_due[$];

  logic [31:0] tb_now;
  int unsigned failures = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned settings_done = 0;
  int unsigned act_seen [8];
  int unsigned burst_left = 0;
  int unsigned quiet = 0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  bit          rx_phase = 1'b0;

  joystick_gesture_recorder #(
    .GESTURE_CHARS(GESTURE_CHARS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void emit(jgr_action_e a, bit stop, logic [6:0] sym, bit fin);
    jgr_out_t r;
    r.action = a;
    r.dome_enabled = dome;
    r.motor_stop = stop;
    r.gesture_symbol = sym;
    r.last = fin;
    outcome.push_back(r);
  endfunction

  function automatic void store_symbol(logic [6:0] s, logic [31:0] t);
    if (stored_n < GESTURE_CHARS) begin
      stored[stored_n] = s;
      stored_n++;
      deadline_ms = t + cfg.gesture_timeout_ms;
    end
  endfunction

  function automatic void recorder_step(jgr_in_t it);
    logic [31:0] gap;
    logic [31:0] late;
    int unsigned ax;
    int unsigned ay;
    int unsigned keep;
    bit          xneg;
    bit          yneg;
    outcome.delete();
    xneg = it.stick_x[7];
    yneg = it.stick_y[7];
    ax = xneg ? 256 - it.stick_x[7:0] : it.stick_x[7:0];
    ay = yneg ? 256 - it.stick_y[7:0] : it.stick_y[7:0];
    if (it.opcode == OP_CONNECT) begin
      dome = 1'b1;
      prev_ms = it.now_ms;
      emit(ACT_CONNECTED, 1'b0, SYM_NONE, 1'b1);
      return;
    end
    if (it.opcode == OP_DISCONNECT) begin
      dome = 1'b0;
      emit(ACT_DISCONNECTED, 1'b1, SYM_NONE, 1'b1);
      return;
    end
    if (it.opcode != OP_REPORT) return;

    gap = (it.now_ms > prev_ms) ? it.now_ms - prev_ms : '0;
    prev_ms = it.now_ms;
    if (gap > cfg.disconnect_lag_ms) begin
      emit(ACT_DISCONNECT, 1'b1, SYM_NONE, 1'b1);
      return;
    end
    if (gap > cfg.stop_lag_ms) begin
      emit(ACT_LAG_STOP, 1'b1, SYM_NONE, 1'b1);
      return;
    end
    if (!capturing) begin
      if (it.released_buttons[0]) begin
        dome = 1'b0;
        capturing = 1'b1;
        stored_n = 0;
        deadline_ms = it.now_ms + cfg.gesture_timeout_ms;
        emit(ACT_STARTED, 1'b1, SYM_NONE, 1'b1);
      end else begin
        emit(ACT_PROCESSED, 1'b0, SYM_NONE, 1'b1);
      end
      return;
    end

    late = it.now_ms - deadline_ms;
    if (late != 0 && !late[31]) begin
      dome = 1'b1;
      capturing = 1'b0;
      stored_n = 0;
      emit(ACT_TIMEOUT, 1'b0, SYM_NONE, 1'b1);
      return;
    end

    if (it.released_buttons[0]) begin
      keep = stored_n;
      if (keep > 0 && stored[keep-1] == SYM_FIVE) keep--;
      dome = 1'b1;
      capturing = 1'b0;
      stored_n = 0;
      if (keep == 0) emit(ACT_DONE, 1'b0, SYM_NONE, 1'b1);
      for (int unsigned k = 0; k < keep; k++) begin
        emit(ACT_DONE, 1'b0, stored[k], k + 1 == keep);
      end
      return;
    end

    for (int i = 0; i < 7; i++) begin
      if (it.released_buttons[i+1]) store_symbol(KEY_LETTERS[7*i +: 7], it.now_ms);
    end
    if (held_dir == SYM_NONE) begin
      if (ax > cfg.diagonal_threshold && ay > cfg.diagonal_threshold) begin
        if (xneg) held_dir = yneg ? SYM_1 : SYM_7;
        else held_dir = yneg ? SYM_3 : SYM_9;
        store_symbol(held_dir, it.now_ms);
      end else if (ax > cfg.axis_threshold) begin
        held_dir = xneg ? SYM_4 : SYM_6;
        store_symbol(held_dir, it.now_ms);
      end else if (ay > cfg.axis_threshold) begin
        held_dir = yneg ? SYM_2 : SYM_8;
        store_symbol(held_dir, it.now_ms);
      end
    end
    if (held_dir != SYM_NONE && ax < cfg.center_threshold && ay < cfg.center_threshold) begin
      store_symbol(SYM_FIVE, it.now_ms);
      held_dir = SYM_NONE;
    end
    emit(ACT_PROCESSED, 1'b0, SYM_NONE, 1'b1);
  endfunction

  function automatic plan_row_t mk_row(logic [1:0] op, logic [31:0] t, logic [7:0] b,
                                       logic [7:0] x, logic [7:0] y, bit typed,
                                       jgr_action_e act, bit dome_after, bit stop);
    plan_row_t r;
    r.item.opcode = op;
    r.item.now_ms = t;
    r.item.released_buttons = b;
    r.item.stick_x = x;
    r.item.stick_y = y;
    r.typed = typed;
    r.want.action = act;
    r.want.dome_enabled = dome_after;
    r.want.motor_stop = stop;
    r.want.gesture_symbol = SYM_NONE;
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] stick_small();
    return 8'(int'($urandom_range(0, 18)) - 9);
  endfunction

  function automatic logic [7:0] stick_far();
    logic [7:0] m;
    m = ($urandom_range(0, 3) == 0) ? 8'd128 : 8'($urandom_range(30, 127));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [7:0] stick_any();
    case ($urandom_range(0, 2))
      0: return 8'($urandom);
      1: return stick_small();
      default: return stick_far();
    endcase
  endfunction

  function automatic logic [7:0] sparse_buttons();
    return 8'($urandom) & 8'($urandom) & 8'($urandom) & 8'hFE;
  endfunction

  function automatic jgr_in_t next_random_item();
    jgr_in_t     it;
    int unsigned roll;
    int unsigned lim;
    it = '0;
    it.opcode = OP_REPORT;
    it.stick_x = stick_any();
    it.stick_y = stick_any();
    roll = $urandom_range(0, 99);
    lim = (cfg.stop_lag_ms < 400) ? cfg.stop_lag_ms : 400;
    if (roll < 4) begin
      it.opcode = OP_UNUSED;
      it.now_ms = $urandom;
      it.released_buttons = 8'($urandom);
    end else if (roll < 9) begin
      it.opcode = OP_CONNECT;
      tb_now += $urandom_range(0, lim);
      it.now_ms = tb_now;
    end else if (roll < 12) begin
      it.opcode = OP_DISCONNECT;
      it.now_ms = $urandom;
      it.released_buttons = 8'($urandom);
    end else if (roll < 18) begin
      case ($urandom_range(0, 3))
        0, 1: tb_now += cfg.stop_lag_ms + $urandom_range(1, 6000);
        2: tb_now = $urandom;
        default: tb_now -= $urandom_range(1, 2000);
      endcase
      it.now_ms = tb_now;
      it.released_buttons = 8'($urandom);
    end else begin
      if ($urandom_range(0, 3) != 0) tb_now += $urandom_range(0, lim);
      it.now_ms = tb_now;
      if (!capturing) begin
        it.released_buttons = sparse_buttons();
        if ($urandom_range(0, 2) == 0) it.released_buttons[0] = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        it.released_buttons = sparse_buttons() | 8'h01;
      end else begin
        it.released_buttons = sparse_buttons();
        if (held_dir != SYM_NONE && $urandom_range(0, 1)) begin
          it.stick_x = stick_small();
          it.stick_y = stick_small();
        end else begin
          case ($urandom_range(0, 2))
            0: begin it.stick_x = stick_far(); it.stick_y = stick_far(); end
            1: begin it.stick_x = stick_far(); it.stick_y = stick_small(); end
            default: begin it.stick_x = stick_small(); it.stick_y = stick_far(); end
          endcase
        end
      end
    end
    return it;
  endfunction

  task automatic offer(input jgr_in_t it, input bit typed, input jgr_out_t want);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    recorder_step(it);
    items_taken++;
    if (typed) results_due.push_back(want);
    else foreach (outcome[k]) results_due.push_back(outcome[k]);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input jgr_reg_e idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $error("register %s: expected %0d, got %0d", idx.name(), v, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STOP_LAG:  cfg.stop_lag_ms = v[15:0];
      REG_DISC_LAG:  cfg.disconnect_lag_ms = v[15:0];
      REG_TIMEOUT:   cfg.gesture_timeout_ms = v[15:0];
      REG_DIAG_TH:   cfg.diagonal_threshold = v[7:0];
      REG_AXIS_TH:   cfg.axis_threshold = v[7:0];
      REG_CENTER_TH: cfg.center_threshold = v[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned stop, input int unsigned disc,
                               input int unsigned tmo, input int unsigned diag,
                               input int unsigned axis, input int unsigned ctr);
    set_reg(REG_STOP_LAG, stop);
    set_reg(REG_DISC_LAG, disc);
    set_reg(REG_TIMEOUT, tmo);
    set_reg(REG_DIAG_TH, diag);
    set_reg(REG_AXIS_TH, axis);
    set_reg(REG_CENTER_TH, ctr);
    @(posedge clk);
    settings_done++;
  endtask

  task automatic field_cmp(input string name, input logic [31:0] w, input logic [31:0] g);
    if (g !== w) begin
      $error("%s: expected %0d, got %0d", name, w, g);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      act_seen[out_data.action]++;
      if (results_due.size() == 0) begin
        $error("result with no transaction pending: action %0d symbol %0d",
               out_data.action, out_data.gesture_symbol);
        failures++;
      end else begin
        field_cmp("action", results_due[0].action, out_data.action);
        field_cmp("dome_enabled", results_due[0].dome_enabled, out_data.dome_enabled);
        field_cmp("motor_stop", results_due[0].motor_stop, out_data.motor_stop);
        field_cmp("gesture_symbol", results_due[0].gesture_symbol, out_data.gesture_symbol);
        field_cmp("last", results_due[0].last, out_data.last);
        void'(results_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left--;
      end
      rx_phase = !rx_phase;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= rx_phase;
        2: out_ready <= ($urandom_range(0, 99) < 60);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    jgr_in_t   it;
    int        sent;
    cfg.stop_lag_ms = RST_STOP_LAG;
    cfg.disconnect_lag_ms = RST_DISC_LAG;
    cfg.gesture_timeout_ms = RST_TIMEOUT;
    cfg.diagonal_threshold = RST_DIAG_TH;
    cfg.axis_threshold = RST_AXIS_TH;
    cfg.center_threshold = RST_CENTER_TH;
    prev_ms = '0;
    deadline_ms = '0;
    capturing = 1'b0;
    dome = 1'b0;
    stored_n = 0;
    held_dir = SYM_NONE;
    tb_now = '0;
    foreach (act_seen[k]) act_seen[k] = 0;

    plan.push_back(mk_row(OP_REPORT, 0, 8'h00, 8'h00, 8'h00, 1, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_UNUSED, 0, 8'hFF, 8'h7F, 8'h80, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_CONNECT, 100, 8'h00, 8'h00, 8'h00, 1, ACT_CONNECTED, 1, 0));
    plan.push_back(mk_row(OP_REPORT, 5101, 8'h00, 8'h00, 8'h00, 1, ACT_DISCONNECT, 1, 1));
    plan.push_back(mk_row(OP_REPORT, 5402, 8'h00, 8'h00, 8'h00, 1, ACT_LAG_STOP, 1, 1));
    plan.push_back(mk_row(OP_REPORT, 5702, 8'h00, 8'h00, 8'h00, 1, ACT_PROCESSED, 1, 0));
    plan.push_back(mk_row(OP_REPORT, 5702, 8'h01, 8'h00, 8'h00, 1, ACT_STARTED, 0, 1));
    plan.push_back(mk_row(OP_REPORT, 5710, 8'hFE, 8'h80, 8'h80, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5720, 8'h00, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5730, 8'h00, 8'h7F, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5740, 8'h00, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5750, 8'h00, 8'h00, 8'h80, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5760, 8'h00, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5770, 8'hFE, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5790, 8'hFF, 8'h80, 8'h7F, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5800, 8'h01, 8'h00, 8'h00, 1, ACT_STARTED, 0, 1));
    plan.push_back(mk_row(OP_REPORT, 5810, 8'h00, 8'h7F, 8'h7F, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5820, 8'h00, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5830, 8'h01, 8'h00, 8'h00, 0, ACT_PROCESSED, 0, 0));
    plan.push_back(mk_row(OP_REPORT, 5840, 8'h01, 8'h00, 8'h00, 1, ACT_STARTED, 0, 1));
    plan.push_back(mk_row(OP_REPORT, 5850, 8'h01, 8'h00, 8'h00, 1, ACT_DONE, 1, 0));
    plan.push_back(mk_row(OP_REPORT, 5860, 8'h01, 8'h00, 8'h00, 1, ACT_STARTED, 0, 1));
    plan.push_back(mk_row(OP_DISCONNECT, 0, 8'h00, 8'h00, 8'h00, 1, ACT_DISCONNECTED, 0, 1));
    plan.push_back(mk_row(OP_CONNECT, 7861, 8'h00, 8'h00, 8'h00, 1, ACT_CONNECTED, 1, 0));
    plan.push_back(mk_row(OP_REPORT, 7861, 8'h00, 8'h00, 8'h00, 1, ACT_TIMEOUT, 1, 0));
    plan.push_back(mk_row(OP_REPORT, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 1,
                          ACT_DISCONNECT, 1, 1));
    plan.push_back(mk_row(OP_REPORT, 0, 8'h00, 8'h00, 8'h00, 1, ACT_PROCESSED, 1, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].item, plan[i].typed, plan[i].want);
      pace();
    end
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apply_setting(250, 3000, 900, 40, 90, 20);
        1: apply_setting(0, 0, 1, 0, 0, 0);
        2: begin
          apply_setting(65535, 65535, 65535, 128, 0, 255);
          tb_now = 32'hFFFF_F000;
        end
        default: apply_setting($urandom_range(50, 600), $urandom_range(600, 8000),
                               $urandom_range(100, 3000), $urandom_range(20, 80), 128,
                               $urandom_range(5, 30));
      endcase
      // The receiver holds off for a long stretch here while items keep coming.
      if (ph == 0) long_hold_req = 1'b1;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        it = next_random_item();
        offer(it, 1'b0, '0);
        if (it.opcode != OP_UNUSED) sent++;
        pace();
      end
      settle();
    end

    $display("tb_top: %0d items in, %0d results checked over %0d register settings.",
             items_taken, results_seen, settings_done);
    $display("tb_top: starts %0d, symbols out %0d, timeouts %0d, lag stops %0d, drops %0d.",
             act_seen[ACT_STARTED], act_seen[ACT_DONE], act_seen[ACT_TIMEOUT],
             act_seen[ACT_LAG_STOP], act_seen[ACT_DISCONNECT]);
    if (failures == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
